/* src/iprt_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4 route table package
// Shared types, codes and helpers for the prefix route table.
// ----------------------------------------------------------------------------
package iprt_pkg;

  localparam int unsigned TableEntriesDefault = 16;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic        gateway_given;
    logic [31:0] gateway_addr;
    logic        source_given;
    logic [31:0] source_addr_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        route_found;
    logic        is_local;
    logic [31:0] next_hop;
    logic        source_valid;
    logic [31:0] source_addr_out;
  } out_item_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  length;
    logic [31:0] gateway;
    logic        has_gateway;
    logic [31:0] source;
    logic        has_source;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_REQ,
    S_SCAN_CHK,
    S_SHIFT_REQ,
    S_SHIFT_WR,
    S_PLACE_REQ,
    S_PLACE_WR,
    S_SRC_REQ,
    S_SRC_WR,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_req;
    logic chk;
    logic ptr_inc;
    logic ptr_dec;
    logic ptr_pos;
    logic ptr_pos1;
    logic ptr_cnt;
    logic shift_wr;
    logic place_wr;
    logic src_wr;
    logic cnt_inc;
    logic cnt_dec;
    logic reply;
  } ctrl_t;

  typedef struct packed {
    logic       is_add;
    logic       is_del;
    logic       ptr_at_end;
    logic       ptr_at_pos;
    logic       hit;
    logic       merged;
    logic       full;
    logic       src_given;
    logic       del_mode;
  } stat_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [63:0] m;
    m = {64{1'b1}} << (7'd32 - {1'b0, len});
    return m[31:0];
  endfunction

endpackage

/* src/iprt_datapath.sv */
// ----------------------------------------------------------------------------
// IPv4 route table datapath
// Entry memory, walk pointer, match logic and result register.
// ----------------------------------------------------------------------------
module iprt_datapath #(
  parameter int unsigned TABLE_ENTRIES = iprt_pkg::TableEntriesDefault,
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  iprt_pkg::in_item_t in_item,
  input  iprt_pkg::ctrl_t    ctrl,
  output iprt_pkg::stat_t    stat,
  output iprt_pkg::out_item_t out_item
);
  import iprt_pkg::*;

  entry_t        mem [TABLE_ENTRIES];
  entry_t        rd_r;
  in_item_t      req_r, req_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] ins_r;
  logic          ins_seen_r;
  logic          merged_r;
  logic          found_r;
  logic          del_r;
  logic          full_r;
  out_item_t     res_r, res_nxt;
  logic [5:0]    len_sat;
  logic [31:0]   mask;
  logic          dup, ins_pt, lk_hit;
  entry_t        wr_data;
  logic          wr_en;
  logic [CW-1:0] wr_addr;

  assign len_sat = (in_item.prefix_len > 6'd32) ? 6'd32 : in_item.prefix_len;
  assign mask   = prefix_mask(rd_r.length);
  assign dup    = (rd_r.length == req_r.prefix_len) && (rd_r.prefix == req_r.address);
  assign ins_pt = (req_r.prefix_len >= rd_r.length);
  assign lk_hit = ((rd_r.prefix & mask) == (req_r.address & mask));

  always_comb begin
    req_nxt = in_item;
    req_nxt.prefix_len = len_sat;
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (ctrl.load) ptr_nxt = '0;
    else if (ctrl.ptr_inc) ptr_nxt = ptr_r + 1'b1;
    else if (ctrl.ptr_dec) ptr_nxt = ptr_r - 1'b1;
    else if (ctrl.ptr_pos) ptr_nxt = pos_r;
    else if (ctrl.ptr_pos1) ptr_nxt = pos_r + 1'b1;
    else if (ctrl.ptr_cnt) ptr_nxt = cnt_r;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = rd_r;
    if (ctrl.shift_wr) begin
      wr_en = 1'b1;
      if (del_r) wr_addr = ptr_r - 1'b1;
      else wr_addr = ptr_r + 1'b1;
    end else if (ctrl.place_wr) begin
      wr_en = 1'b1;
      wr_addr = pos_r;
      if (!merged_r) begin
        wr_data = '0;
        wr_data.prefix = req_r.address;
        wr_data.length = req_r.prefix_len;
      end
      if (req_r.gateway_given) begin
        wr_data.gateway = req_r.gateway_addr;
        wr_data.has_gateway = 1'b1;
      end
      if (req_r.source_given) begin
        wr_data.source = req_r.source_addr_in;
        wr_data.has_source = 1'b1;
      end
    end else if (ctrl.src_wr) begin
      wr_en = !rd_r.has_source;
      wr_data.source = req_r.source_addr_in;
      wr_data.has_source = 1'b1;
    end
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.status = ST_NOMATCH;
    if (req_r.action == ACT_ADD) begin
      res_nxt.status = (!merged_r && full_r) ? ST_FULL : ST_DONE;
    end else if (req_r.action == ACT_DELETE) begin
      res_nxt.status = del_r ? ST_DONE : ST_NOMATCH;
    end else if (req_r.action == ACT_LOOKUP && found_r) begin
      res_nxt.status = ST_DONE;
      res_nxt.route_found = 1'b1;
      res_nxt.is_local = !rd_r.has_gateway;
      res_nxt.next_hop = rd_r.has_gateway ? rd_r.gateway : req_r.address;
      res_nxt.source_valid = rd_r.has_source;
      res_nxt.source_addr_out = rd_r.has_source ? rd_r.source : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_req) rd_r <= mem[ptr_nxt[AW-1:0]];
    if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
    if (ctrl.load) req_r <= req_nxt;
    if (ctrl.reply) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
      pos_r <= '0;
      merged_r <= 1'b0;
      found_r <= 1'b0;
      del_r <= 1'b0;
      full_r <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      if (ctrl.cnt_inc) cnt_r <= cnt_r + 1'b1;
      else if (ctrl.cnt_dec) cnt_r <= cnt_r - 1'b1;
      if (ctrl.load) begin
        pos_r <= cnt_r;
        merged_r <= 1'b0;
        found_r <= 1'b0;
        del_r <= 1'b0;
        full_r <= stat.full;
      end else if (ctrl.chk && stat.hit && !found_r) begin
        found_r <= 1'b1;
        if (stat.is_add) begin
          pos_r <= ptr_r;
          merged_r <= 1'b1;
        end
        if (stat.is_del) del_r <= 1'b1;
      end else if (ctrl.ptr_cnt) begin
        pos_r <= ins_r;
      end
    end
  end

  // Insertion point: first entry not longer than the new one.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ins_r <= cnt_r;
      ins_seen_r <= 1'b0;
    end else if (ctrl.chk && !stat.hit && ins_pt && !ins_seen_r) begin
      ins_r <= ptr_r;
      ins_seen_r <= 1'b1;
    end
  end

  always_comb begin
    stat = '0;
    stat.is_add     = (req_r.action == ACT_ADD);
    stat.is_del     = (req_r.action == ACT_DELETE);
    stat.ptr_at_end = (ptr_r >= cnt_r);
    stat.ptr_at_pos = (ptr_r == pos_r);
    stat.hit        = stat.is_add ? dup : (stat.is_del ? dup : lk_hit);
    stat.merged     = merged_r;
    stat.full       = (cnt_r >= CW'(TABLE_ENTRIES));
    stat.src_given  = req_r.source_given;
    stat.del_mode   = del_r;
  end

  assign out_item = res_r;

endmodule

/* src/iprt_ctrl.sv */
// ----------------------------------------------------------------------------
// IPv4 route table controller
// Sequences scan, shift, place and source fill passes over the entry memory.
// ----------------------------------------------------------------------------
module iprt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  input  iprt_pkg::stat_t stat,
  output iprt_pkg::ctrl_t ctrl
);
  import iprt_pkg::*;

  state_t state_r, state_nxt;
  logic   valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (start) state_nxt = S_SCAN_REQ;
      S_SCAN_REQ:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (stat.ptr_at_end) begin
          if (stat.is_add) state_nxt = stat.full ? S_REPLY : S_SHIFT_REQ;
          else state_nxt = S_REPLY;
        end else if (stat.hit) begin
          if (stat.is_add) state_nxt = S_PLACE_REQ;
          else if (stat.is_del) state_nxt = S_SHIFT_REQ;
          else state_nxt = S_REPLY;
        end else state_nxt = S_SCAN_REQ;
      end
      S_SHIFT_REQ: state_nxt = (stat.del_mode ? stat.ptr_at_end : stat.ptr_at_pos)
                               ? (stat.del_mode ? S_REPLY : S_PLACE_REQ) : S_SHIFT_WR;
      S_SHIFT_WR:  state_nxt = S_SHIFT_REQ;
      S_PLACE_REQ: state_nxt = S_PLACE_WR;
      S_PLACE_WR:  state_nxt = stat.src_given ? S_SRC_REQ : S_REPLY;
      S_SRC_REQ:   state_nxt = stat.ptr_at_end ? S_REPLY : S_SRC_WR;
      S_SRC_WR:    state_nxt = S_SRC_REQ;
      S_REPLY:     state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      S_IDLE:      ctrl.load = start;
      S_SCAN_REQ:  ctrl.rd_req = 1'b1;
      S_SCAN_CHK: begin
        if (stat.ptr_at_end) begin
          if (stat.is_add && !stat.full) ctrl.ptr_cnt = 1'b1;
        end else begin
          ctrl.chk = 1'b1;
          if (!stat.hit || stat.is_del) ctrl.ptr_inc = 1'b1;
        end
      end
      S_SHIFT_REQ: begin
        if (stat.del_mode) begin
          if (stat.ptr_at_end) ctrl.cnt_dec = 1'b1;
          else ctrl.rd_req = 1'b1;
        end else if (!stat.ptr_at_pos) begin
          ctrl.ptr_dec = 1'b1;
          ctrl.rd_req = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        ctrl.shift_wr = 1'b1;
        if (stat.del_mode) ctrl.ptr_inc = 1'b1;
      end
      S_PLACE_REQ: begin
        ctrl.rd_req = 1'b1;
        ctrl.ptr_pos = 1'b1;
        if (!stat.merged) ctrl.cnt_inc = 1'b1;
      end
      S_PLACE_WR:  begin
        ctrl.place_wr = 1'b1;
        ctrl.ptr_pos1 = 1'b1;
      end
      S_SRC_REQ:   if (!stat.ptr_at_end) ctrl.rd_req = 1'b1;
      S_SRC_WR: begin
        ctrl.src_wr = 1'b1;
        ctrl.ptr_inc = 1'b1;
      end
      S_REPLY:     ctrl.reply = 1'b1;
      default:     ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= ctrl.reply;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = valid_r;

  a_reply_once: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> state_r == S_IDLE) else $error("strobe outside idle");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |=> state_r == S_SCAN_REQ) else $error("load did not start scan");
  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({ctrl.shift_wr, ctrl.place_wr, ctrl.src_wr}) <= 1)
    else $error("two writes at once");

endmodule

/* src/ipv4_prefix_route_table_top.sv */
// ----------------------------------------------------------------------------
// IPv4 prefix route table
// Longest-prefix-first route table with add, delete and lookup commands.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low. The walk reads the
// entries of the single-port entry memory one at a time, with a read request
// state and a check state per entry. An add or delete also shifts the entries
// it moves, with one read and one write per entry, and an add that supplies a
// source also fills it into the entries after the new one that have none. The
// result appears for one cycle with out_valid and cannot be held off; busy drops in
// that same cycle, so the next command can be taken at the edge that ends it.
module ipv4_prefix_route_table_top #(
  parameter int unsigned TABLE_ENTRIES = iprt_pkg::TableEntriesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  iprt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output iprt_pkg::out_item_t out_item
);
  import iprt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  iprt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .stat(stat), .ctrl(ctrl)
  );

  iprt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .ctrl(ctrl),
    .stat(stat), .out_item(out_item)
  );

endmodule

/* tb/sv/tb_ipv4_prefix_route_table_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route table regression bench
// Drives add, delete and lookup commands into the prefix route table, keeps a
// sorted shadow table to predict every reply, and checks each reply in order.
// ----------------------------------------------------------------------------
module tb_ipv4_prefix_route_table_top;
  import iprt_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 2000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;

  ipv4_prefix_route_table_top #(.TABLE_ENTRIES(Depth)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  entry_t shadow[Depth];
  int unsigned shadow_cnt;
  in_item_t cmd_q[$];
  out_item_t reply_q[$];
  int unsigned sender_idle_pct;
  int unsigned errors, replies_seen, cycles;
  int unsigned n_add, n_del, n_lookup, n_full, n_hit;
  logic [31:0] pool[8];

  function automatic logic [31:0] len_mask(input int unsigned len);
    logic [63:0] m;
    m = {64{1'b1}} << (32 - len);
    return m[31:0];
  endfunction

  function automatic out_item_t route_apply(input in_item_t c);
    out_item_t r;
    int unsigned len, pos, k;
    logic merged;
    logic [31:0] m;
    r = '0;
    r.status = ST_NOMATCH;
    len = (c.prefix_len > 32) ? 32 : c.prefix_len;
    case (action_t'(c.action))
      ACT_ADD: begin
        n_add++;
        pos = shadow_cnt;
        merged = 1'b0;
        for (k = 0; k < shadow_cnt; k++)
          if (!merged && shadow[k].length == len && shadow[k].prefix == c.address) begin
            pos = k;
            merged = 1'b1;
          end
        if (!merged && shadow_cnt >= Depth) begin
          r.status = ST_FULL;
          n_full++;
          return r;
        end
        if (!merged) begin
          for (k = shadow_cnt; k > 0; k--)
            if (len >= shadow[k-1].length) pos = k - 1;
          for (k = shadow_cnt; k > pos; k--) shadow[k] = shadow[k-1];
          shadow[pos] = '0;
          shadow[pos].prefix = c.address;
          shadow[pos].length = len[5:0];
          shadow_cnt++;
        end
        if (c.gateway_given) begin
          shadow[pos].gateway = c.gateway_addr;
          shadow[pos].has_gateway = 1'b1;
        end
        if (c.source_given)
          for (k = pos; k < shadow_cnt; k++)
            if (k == pos || !shadow[k].has_source) begin
              shadow[k].source = c.source_addr_in;
              shadow[k].has_source = 1'b1;
            end
        r.status = ST_DONE;
      end
      ACT_DELETE: begin
        n_del++;
        for (k = 0; k < shadow_cnt; k++)
          if (shadow[k].prefix == c.address && shadow[k].length == len) begin
            for (pos = k; pos + 1 < shadow_cnt; pos++) shadow[pos] = shadow[pos+1];
            shadow_cnt--;
            r.status = ST_DONE;
            break;
          end
      end
      ACT_LOOKUP: begin
        n_lookup++;
        for (k = 0; k < shadow_cnt; k++) begin
          m = len_mask(shadow[k].length);
          if ((shadow[k].prefix & m) == (c.address & m)) begin
            n_hit++;
            r.status = ST_DONE;
            r.route_found = 1'b1;
            r.is_local = !shadow[k].has_gateway;
            r.next_hop = shadow[k].has_gateway ? shadow[k].gateway : c.address;
            if (shadow[k].has_source) begin
              r.source_valid = 1'b1;
              r.source_addr_out = shadow[k].source;
            end
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_cmd(input action_t act, input logic [31:0] addr,
                                        input logic [5:0] len);
    in_item_t c;
    c = '0;
    c.action = act;
    c.address = addr;
    c.prefix_len = len;
    return c;
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t c;
    int unsigned pick;
    c.gateway_given = 1'($urandom_range(0, 1));
    c.gateway_addr = $urandom;
    c.source_given = $urandom_range(0, 2) == 0;
    c.source_addr_in = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 3) c.prefix_len = 6'($urandom_range(33, 63));
    else if (pick < 20) c.prefix_len = 6'($urandom_range(0, 32));
    else c.prefix_len = 6'(8 * $urandom_range(0, 4));
    c.address = ($urandom_range(0, 3) == 0) ? $urandom : pool[3'($urandom_range(0, 7))];
    if ($urandom_range(0, 9) == 0) c.address ^= 32'h1 << $urandom_range(0, 31);
    pick = $urandom_range(0, 99);
    if (pick < 40) c.action = ACT_ADD;
    else if (pick < 60) c.action = ACT_DELETE;
    else if (pick < 98) c.action = ACT_LOOKUP;
    else c.action = ACT_NONE;
    if (c.action == ACT_LOOKUP && $urandom_range(0, 1))
      c.address = pool[3'($urandom_range(0, 7))] | ($urandom & 32'h0000_ffff);
    return c;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      if (cmd_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_item <= cmd_q[0];
        reply_q.push_back(route_apply(cmd_q.pop_front()));
      end else begin
        start <= 1'b0;
      end
    end else if (!start && cmd_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
      in_item <= cmd_q[0];
      reply_q.push_back(route_apply(cmd_q.pop_front()));
      start <= 1'b1;
    end
  end

  // The shadow table is updated when the command is presented, which is safe
  // because the block accepts a command only after the previous reply.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      replies_seen <= replies_seen + 1;
      if (reply_q.size() == 0) begin
        $display("%0t: reply with no command pending: %p", $time, out_item);
        errors <= errors + 1;
      end else if (out_item !== reply_q[0]) begin
        $display("%0t: reply mismatch: expected %p, actual %p", $time, reply_q[0],
                 out_item);
        errors <= errors + 1;
        void'(reply_q.pop_front());
      end else begin
        void'(reply_q.pop_front());
      end
    end
  end

  task automatic run_phase(input int unsigned idle_pct, input int unsigned n);
    int unsigned k;
    sender_idle_pct = idle_pct;
    for (k = 0; k < n; k++) cmd_q.push_back(random_cmd());
    while (cmd_q.size() > 0 || reply_q.size() > 0 || start) @(posedge clk);
  endtask

  initial begin
    int unsigned k;
    in_item_t c;
    start = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    cycles = 0;
    errors = 0;
    replies_seen = 0;
    shadow_cnt = 0;
    sender_idle_pct = 0;
    for (k = 0; k < Depth; k++) shadow[k] = '0;
    for (k = 0; k < 8; k++) pool[k] = $urandom;
    pool[0] = 32'h0;
    pool[1] = 32'hffff_ffff;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    cmd_q.push_back(make_cmd(ACT_LOOKUP, 32'h0a00_0001, 6'd0));
    cmd_q.push_back(make_cmd(ACT_DELETE, 32'h0a00_0000, 6'd8));
    c = make_cmd(ACT_ADD, 32'h0a00_0000, 6'd8);
    c.gateway_given = 1'b1;
    c.gateway_addr = 32'hffff_ffff;
    cmd_q.push_back(c);
    cmd_q.push_back(make_cmd(ACT_LOOKUP, 32'h0aff_ffff, 6'd0));
    c = make_cmd(ACT_ADD, 32'h0a01_0203, 6'd16);
    c.source_given = 1'b1;
    c.source_addr_in = 32'hffff_ffff;
    cmd_q.push_back(c);
    cmd_q.push_back(make_cmd(ACT_LOOKUP, 32'h0a01_ffff, 6'd0));
    c = make_cmd(ACT_ADD, 32'h0a00_0000, 6'd8);
    c.source_given = 1'b1;
    c.source_addr_in = 32'h0000_0000;
    cmd_q.push_back(c);
    cmd_q.push_back(make_cmd(ACT_ADD, 32'hffff_ffff, 6'd63));
    cmd_q.push_back(make_cmd(ACT_LOOKUP, 32'hffff_ffff, 6'd0));
    cmd_q.push_back(make_cmd(ACT_ADD, 32'h1234_5678, 6'd0));
    cmd_q.push_back(make_cmd(ACT_LOOKUP, 32'h8765_4321, 6'd0));
    cmd_q.push_back(make_cmd(ACT_NONE, 32'hffff_ffff, 6'd63));
    cmd_q.push_back(make_cmd(ACT_DELETE, 32'h1234_5678, 6'd0));
    cmd_q.push_back(make_cmd(ACT_DELETE, 32'hffff_ffff, 6'd40));
    for (k = 0; k < 18; k++) cmd_q.push_back(make_cmd(ACT_ADD, k << 4, 6'd28));
    c = make_cmd(ACT_ADD, 32'h0a00_0000, 6'd8);
    c.gateway_given = 1'b1;
    c.gateway_addr = 32'h0102_0304;
    cmd_q.push_back(c);
    cmd_q.push_back(make_cmd(ACT_LOOKUP, 32'h0a09_0909, 6'd0));
    for (k = 0; k < 18; k++) cmd_q.push_back(make_cmd(ACT_DELETE, k << 4, 6'd28));
    run_phase(0, 0);

    run_phase(10, 550);
    run_phase(81, 300);
    run_phase(0, 750);
    repeat (60) @(posedge clk);

    $display("Covered %0d adds (%0d table full), %0d deletes, %0d lookups (%0d hits).",
             n_add, n_full, n_del, n_lookup, n_hit);
    $display("%0d replies checked.", replies_seen);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("ipv4_prefix_route_table_top regression: pass");
    end else begin
      $display("ipv4_prefix_route_table_top regression: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("ipv4_prefix_route_table_top regression: fail");
      $finish;
    end
  end

endmodule
